>>> sv/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg: shared definitions for the device table manager
// Field widths, command and status codes, controller states, the entry record,
// the probe and per-cell control bundles and the model-id helper functions.
// ----------------------------------------------------------------------------
package dtm_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_MODEL_BYTES = 8;

  localparam int CMD_W    = 4;
  localparam int NODE_W   = 16;
  localparam int MODEL_W  = 64;
  localparam int LEN_W    = 4;
  localparam int TIME_W   = 32;
  localparam int EIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int USED_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 4'd0,
    CMD_REMOVE     = 4'd1,
    CMD_FIND_NODE  = 4'd2,
    CMD_FIND_MODEL = 4'd3,
    CMD_ONLINE     = 4'd4,
    CMD_OFFLINE    = 4'd5,
    CMD_LED_ON     = 4'd6,
    CMD_LED_OFF    = 4'd7,
    CMD_TIME       = 4'd8,
    CMD_COUNT      = 4'd9,
    CMD_READ       = 4'd10
  } dtm_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_PRESENT   = 2'd3
  } dtm_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_APPLY
  } dtm_state_t;

  typedef struct packed {
    logic [NODE_W-1:0]  key;
    logic [MODEL_W-1:0] model;
    logic               online;
    logic               led;
    logic [TIME_W-1:0]  seen;
  } dtm_entry_t;

  // Search key and write data broadcast to every cell.
  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [MODEL_W-1:0] model;
    logic [LEN_W-1:0]   len;
    logic [TIME_W-1:0]  seen;
  } dtm_probe_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic capture;
    logic by_model;
    logic load;
    logic shift;
    logic set_online;
    logic online_val;
    logic set_led;
    logic led_val;
    logic set_time;
  } dtm_cell_ctl_t;

  // Keeps the first mbytes bytes, up to the first zero byte.
  function automatic logic [MODEL_W-1:0] clean_model(input logic [MODEL_W-1:0] m,
                                                     input int mbytes);
    logic [MODEL_W-1:0] r;
    logic               stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= mbytes || m[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*i +: 8] = m[8*i +: 8];
    end
    return r;
  endfunction

  // Compares the leading bytes; a byte that is zero in both ends the compare as equal.
  function automatic logic prefix_match(input logic [MODEL_W-1:0] stored,
                                        input logic [MODEL_W-1:0] probe,
                                        input logic [LEN_W-1:0] len,
                                        input int mbytes);
    int   n;
    logic ok;
    logic done;
    n    = (int'(len) > mbytes) ? mbytes : int'(len);
    ok   = 1'b1;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!done && i < n) begin
        if (stored[8*i +: 8] != probe[8*i +: 8]) begin
          ok   = 1'b0;
          done = 1'b1;
        end else if (stored[8*i +: 8] == 8'h00) begin
          done = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage

>>> sv/dtm_if.sv
// ----------------------------------------------------------------------------
// dtm_if: command and response channels of the device table manager
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dtm_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [15:0] node_id;
  logic [63:0] model_id;
  logic [3:0]  model_len;
  logic [31:0] timestamp;
  logic [3:0]  entry_index;

  modport source (output valid, cmd, node_id, model_id, model_len, timestamp, entry_index,
                  input ready);
  modport sink (input valid, cmd, node_id, model_id, model_len, timestamp, entry_index,
                output ready);
endinterface

interface dtm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [15:0] found_node;
  logic [63:0] found_model;
  logic        is_online;
  logic        led_lit;
  logic [31:0] seen_time;
  logic [4:0]  entries_used;

  modport source (output valid, status, slot, found_node, found_model, is_online, led_lit,
                  seen_time, entries_used, input ready);
  modport sink (input valid, status, slot, found_node, found_model, is_online, led_lit,
                seen_time, entries_used, output ready);
endinterface

>>> sv/dtm_cell.sv
// ----------------------------------------------------------------------------
// dtm_cell: one table slot
// Holds one entry, compares it against the broadcast key, and on removal takes
// the entry of its upper neighbor.
// ----------------------------------------------------------------------------
module dtm_cell #(
  parameter int MODEL_BYTES = dtm_pkg::DEF_MODEL_BYTES
) (
  input  logic                   clk,
  input  dtm_pkg::dtm_cell_ctl_t ctl,
  input  dtm_pkg::dtm_probe_t    probe,
  input  logic                   active,
  input  dtm_pkg::dtm_entry_t    load_data,
  input  dtm_pkg::dtm_entry_t    neighbor,
  output dtm_pkg::dtm_entry_t    entry,
  output logic                   hit
);
  import dtm_pkg::*;

  dtm_entry_t entry_next;
  logic       match;

  always_comb begin
    if (ctl.by_model) begin
      match = active && prefix_match(entry.model, probe.model, probe.len, MODEL_BYTES);
    end else begin
      match = active && (entry.key == probe.node);
    end
  end

  always_comb begin
    entry_next = entry;
    if (ctl.load) begin
      entry_next = load_data;
    end else if (ctl.shift) begin
      entry_next = neighbor;
    end else begin
      if (ctl.set_online) entry_next.online = ctl.online_val;
      if (ctl.set_led)    entry_next.led    = ctl.led_val;
      if (ctl.set_time)   entry_next.seen   = probe.seen;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctl.capture) hit <= match;
  end

endmodule

>>> sv/device_table_manager_unit.sv
// ----------------------------------------------------------------------------
// device_table_manager_unit: compacting associative table of device entries
// A row of cells, one per slot, kept packed below the entry count. Commands
// add, remove, search, update and read entries; each gives one response.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Carries
//   --------+-----------+-----------------------------------------------------
//   req     | in        | cmd, node_id, model_id, model_len, timestamp,
//           |           | entry_index
//   rsp     | out       | status, slot, found_node, found_model, is_online,
//           |           | led_lit, seen_time, entries_used
//
// Each command passes through the transfer, a match step in which every cell
// compares its entry with the key, a resolve step that picks the lowest
// matching slot through a priority encoder (for a read, the indexed slot) and
// reads it out, and a write-back step that writes the cells and loads the
// response register. The next command is taken in the cycle after write-back.
// The response register parts the two sides: a command is taken while the
// previous response still waits, and only the write-back cycle waits for the
// register to free up when the response side stalls.
// Reset (rst, synchronous) empties the table by clearing the count and holds
// ready low while it is asserted; there is no clearing pass, slot contents
// stay as they were.
//
module device_table_manager_unit #(
  parameter int TABLE_DEPTH = dtm_pkg::DEF_TABLE_DEPTH,
  parameter int MODEL_BYTES = dtm_pkg::DEF_MODEL_BYTES
) (
  input logic     clk,
  input logic     rst,
  dtm_req_if.sink   req,
  dtm_rsp_if.source rsp
);
  import dtm_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RD_W  = IDX_W + EIDX_W;

  // Controller state and entry count.
  dtm_state_t       state;
  dtm_state_t       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Command held for the duration of its work.
  logic [CMD_W-1:0]   cmd_q;
  logic [NODE_W-1:0]  node_q;
  logic [MODEL_W-1:0] model_q;
  logic [LEN_W-1:0]   len_q;
  logic [TIME_W-1:0]  time_q;
  logic [EIDX_W-1:0]  eidx_q;

  // Slot picked in the resolve cycle.
  dtm_entry_t       sel_entry;
  logic [IDX_W-1:0] sel_slot;
  logic             sel_any;

  // Response register.
  logic             out_valid;
  dtm_status_t      out_status;
  logic [IDX_W-1:0] out_slot;
  dtm_entry_t       out_entry;
  logic [CNT_W-1:0] out_count;

  // Row of cells.
  dtm_entry_t    entries [TABLE_DEPTH];
  logic          hits    [TABLE_DEPTH];
  dtm_cell_ctl_t ctl     [TABLE_DEPTH];
  dtm_probe_t    probe;
  dtm_entry_t    new_entry;

  logic             accept;
  logic             out_free;
  logic             do_apply;
  logic             full;
  logic             add_ok;
  logic             del_ok;
  logic [IDX_W-1:0] first_idx;
  logic             first_any;
  logic [RD_W-1:0]  rd_idx;
  logic             rd_ok;
  logic [IDX_W-1:0] pick_idx;
  logic             pick_any;
  dtm_entry_t       mod_entry;
  dtm_status_t      res_status;
  logic [IDX_W-1:0] res_slot;
  dtm_entry_t       res_entry;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign add_ok   = (cmd_q == CMD_ADD) && !full && !sel_any;
  assign del_ok   = (cmd_q == CMD_REMOVE) && sel_any;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (req.valid) state_next = ST_MATCH;
      ST_MATCH:   state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_APPLY;
      ST_APPLY:   if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    do_apply  = 1'b0;
    case (state)
      ST_IDLE:  req.ready = !rst;
      ST_APPLY: do_apply  = out_free;
      default: begin
        req.ready = 1'b0;
        do_apply  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (do_apply) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      node_q  <= req.node_id;
      model_q <= req.model_id;
      len_q   <= req.model_len;
      time_q  <= req.timestamp;
      eidx_q  <= req.entry_index;
    end
  end

  // ---------------------------------------------------------------- cells
  assign probe.node  = node_q;
  assign probe.model = model_q;
  assign probe.len   = len_q;
  assign probe.seen  = time_q;

  // A new entry comes up online, LED off, never seen.
  assign new_entry.key    = node_q;
  assign new_entry.model  = clean_model(model_q, MODEL_BYTES);
  assign new_entry.online = 1'b1;
  assign new_entry.led    = 1'b0;
  assign new_entry.seen   = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic       upd;
    dtm_entry_t upper;

    // The top cell has no upper neighbor; what it keeps lies above the count.
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign upper = entries[i+1];
    end else begin : g_top
      assign upper = entries[i];
    end

    assign upd = do_apply && sel_any && (sel_slot == IDX_W'(i));

    always_comb begin
      ctl[i].capture    = (state == ST_MATCH);
      ctl[i].by_model   = (cmd_q == CMD_FIND_MODEL);
      ctl[i].load       = do_apply && add_ok && (count == CNT_W'(i));
      ctl[i].shift      = do_apply && del_ok && (IDX_W'(i) >= sel_slot);
      ctl[i].set_online = upd && ((cmd_q == CMD_ONLINE) || (cmd_q == CMD_OFFLINE));
      ctl[i].online_val = (cmd_q == CMD_ONLINE);
      ctl[i].set_led    = upd && ((cmd_q == CMD_LED_ON) || (cmd_q == CMD_LED_OFF));
      ctl[i].led_val    = (cmd_q == CMD_LED_ON);
      ctl[i].set_time   = upd && (cmd_q == CMD_TIME);
    end

    dtm_cell #(
      .MODEL_BYTES(MODEL_BYTES)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .probe    (probe),
      .active   (CNT_W'(i) < count),
      .load_data(new_entry),
      .neighbor (upper),
      .entry    (entries[i]),
      .hit      (hits[i])
    );
  end

  // ---------------------------------------------------------------- resolve
  // Lowest matching slot wins.
  always_comb begin
    first_idx = '0;
    first_any = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first_idx = IDX_W'(i);
        first_any = 1'b1;
      end
    end
  end

  assign rd_idx = RD_W'(eidx_q);
  assign rd_ok  = (rd_idx < RD_W'(count));

  always_comb begin
    if (cmd_q == CMD_READ) begin
      pick_idx = rd_idx[IDX_W-1:0];
      pick_any = rd_ok;
    end else begin
      pick_idx = first_idx;
      pick_any = first_any;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESOLVE) begin
      sel_entry <= entries[pick_idx];
      sel_slot  <= pick_idx;
      sel_any   <= pick_any;
    end
  end

  // ---------------------------------------------------------------- write-back
  // The set commands report the entry as it reads after the change.
  always_comb begin
    mod_entry = sel_entry;
    case (cmd_q)
      CMD_ONLINE:  mod_entry.online = 1'b1;
      CMD_OFFLINE: mod_entry.online = 1'b0;
      CMD_LED_ON:  mod_entry.led    = 1'b1;
      CMD_LED_OFF: mod_entry.led    = 1'b0;
      CMD_TIME:    mod_entry.seen   = time_q;
      default:     mod_entry        = sel_entry;
    endcase
  end

  always_comb begin
    res_status = STATUS_DONE;
    res_slot   = '0;
    res_entry  = '0;
    count_next = count;
    case (cmd_q)
      CMD_ADD: begin
        if (full) begin
          res_status = STATUS_FULL;
        end else if (sel_any) begin
          res_status = STATUS_PRESENT;
          res_slot   = sel_slot;
          res_entry  = sel_entry;
        end else begin
          res_slot   = count[IDX_W-1:0];
          res_entry  = new_entry;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (sel_any) begin
          res_slot   = sel_slot;
          res_entry  = sel_entry;
          count_next = count - CNT_W'(1);
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      CMD_FIND_NODE, CMD_FIND_MODEL, CMD_READ: begin
        if (sel_any) begin
          res_slot  = sel_slot;
          res_entry = sel_entry;
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      CMD_ONLINE, CMD_OFFLINE, CMD_LED_ON, CMD_LED_OFF, CMD_TIME: begin
        if (sel_any) begin
          res_slot  = sel_slot;
          res_entry = mod_entry;
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        // Count and the unused codes change nothing and report no entry.
        res_status = STATUS_DONE;
      end
    endcase
  end

  // ---------------------------------------------------------------- response
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_apply) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_apply) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_entry  <= res_entry;
      out_count  <= count_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot         = SLOT_W'(out_slot);
  assign rsp.found_node   = out_entry.key;
  assign rsp.found_model  = out_entry.model;
  assign rsp.is_online    = out_entry.online;
  assign rsp.led_lit      = out_entry.led;
  assign rsp.seen_time    = out_entry.seen;
  assign rsp.entries_used = USED_W'(out_count);

endmodule

>>> sv/dtm_checker.sv
// ----------------------------------------------------------------------------
// dtm_checker: port-level checks for the device table manager
// Watches the command and response channels and flags responses that break
// the table's rules.
// ----------------------------------------------------------------------------
module dtm_checker #(
  parameter int TABLE_DEPTH = dtm_pkg::DEF_TABLE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [3:0]  slot,
  input logic [15:0] found_node,
  input logic [63:0] found_model,
  input logic [31:0] seen_time,
  input logic [4:0]  entries_used
);
  import dtm_pkg::*;

  // A command is worked on through the match, resolve and write-back states, so no transfer follows at once.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command taken in the cycle right after a transfer");

  // A refused add only happens with the table full.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STATUS_FULL) |-> entries_used == 5'(TABLE_DEPTH))
    else $error("table full reported below the depth");

  // Not-found and table-full responses carry zero entry fields.
  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STATUS_NOT_FOUND || status == STATUS_FULL) |->
      slot == 4'd0 && found_node == 16'd0 && found_model == 64'd0 && seen_time == 32'd0)
    else $error("entry fields set on a response without an entry");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entries_used))
    else $error("stalled response changed");

endmodule

bind device_table_manager_unit dtm_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_dtm_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .slot        (rsp.slot),
  .found_node  (rsp.found_node),
  .found_model (rsp.found_model),
  .seen_time   (rsp.seen_time),
  .entries_used(rsp.entries_used)
);
